// ===== sv/sdspi_pkg.sv =====
// Shared types and constants for the SD card SPI-mode init and block write sequencer.
// Used by the channel interfaces and by the top level; depends on nothing.
package sdspi_pkg;

  // Selector codes of a request.
  typedef enum logic [1:0] {
    FUNC_INIT  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_DONE  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_POLL_LIMIT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WAKE_BYTES = 1'd1;

  localparam logic [7:0] POLL_LIMIT_RESET = 8'd100;
  localparam logic [7:0] WAKE_BYTES_RESET = 8'd20;
  localparam int         BLOCK_BYTES_DEF  = 512;

  // Command framing.
  localparam logic [7:0]  CMD_START   = 8'h40;
  localparam logic [5:0]  CMD_GO_IDLE = 6'd0;
  localparam logic [5:0]  CMD_IF_COND = 6'd8;
  localparam logic [5:0]  CMD_APP     = 6'd55;
  localparam logic [5:0]  CMD_OP_COND = 6'd41;
  localparam logic [5:0]  CMD_WRITE   = 6'd24;
  localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
  localparam logic [31:0] ARG_OP_COND = 32'h4000_0000;
  localparam logic [7:0]  CRC_GO_IDLE = 8'h95;
  localparam logic [7:0]  CRC_IF_COND = 8'h87;
  localparam int          CMD_BYTES   = 6;
  localparam int          R7_BYTES    = 4;
  localparam int          CRC_BYTES   = 2;

  // Bus values.
  localparam logic [7:0] BYTE_IDLE   = 8'hFF;
  localparam logic [7:0] TOKEN_START = 8'hFE;
  localparam logic [7:0] REPLY_IDLE  = 8'h01;
  localparam logic [7:0] REPLY_READY = 8'h00;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] block_address;
    logic [7:0]  rx_byte;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    logic       send;
    logic [7:0] tx_byte;
    logic       select_card;
    logic       data_taken;
    logic       finished;
    logic       failed;
    logic [7:0] response;
  } rsp_t;

endpackage

// ===== sv/sdspi_if.sv =====
// Valid/ready channel interfaces for requests and results of the sequencer.
// Depends on sdspi_pkg for the payload types.
interface sdspi_req_if;
  import sdspi_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sdspi_rsp_if;
  import sdspi_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/sd_spi_init_and_block_write.sv =====
// Top level of the SD card SPI-mode init and single block write sequencer.
// Depends on sdspi_pkg and the channel interfaces in sdspi_if.sv.
//
// Usage: each request on req is one step of the sequencer. FUNC_INIT starts
// card initialization, FUNC_WRITE starts a block write at block_address, and
// FUNC_DONE reports that the previous byte exchange finished, with the byte
// read back in rx_byte. Each request yields exactly one result on rsp: either
// the next byte to exchange (send, tx_byte, select_card, data_taken) or an
// end report (finished, failed). response always holds the last card reply.
// When data_taken is set, data_byte of that request was sent as payload.
// One request is accepted every cycle, since the next state and the result
// come from one short decode of the phase register and counters into the
// result register. A start request aborts any running operation.
// Configuration (poll_limit, wake_bytes) is to be written through cfg_write
// only while idle; the sequencer itself does not enforce this.
// Reset is synchronous and leaves the sequencer idle with no result pending.
// If the receiver stalls, the result register holds and req.ready drops until
// the result is taken; a new request is accepted in the cycle it is taken.
module sd_spi_init_and_block_write #(
  parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  sdspi_req_if.sink                          req,
  sdspi_rsp_if.source                        rsp,
  input  logic                               cfg_write,
  input  logic [sdspi_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sdspi_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sdspi_pkg::*;

  localparam int CW = ($clog2(BLOCK_BYTES) > 8) ? $clog2(BLOCK_BYTES) : 8;

  typedef enum logic [4:0] {
    PH_IDLE, PH_WAKE,
    PH_C0_SEND, PH_C0_POLL, PH_C0_TAIL,
    PH_C8_SEND, PH_C8_POLL, PH_C8_R7, PH_C8_TAIL,
    PH_C55_SEND, PH_C55_POLL, PH_C55_TAIL,
    PH_C41_SEND, PH_C41_POLL, PH_C41_TAIL,
    PH_C24_SEND, PH_C24_POLL,
    PH_TOKEN, PH_DATA, PH_CRC, PH_DRESP, PH_BUSY, PH_W_TAIL
  } phase_t;

  logic [7:0]    poll_limit;
  logic [7:0]    wake_bytes;
  phase_t        phase, phase_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [7:0]    poll_count, poll_count_next;
  logic [31:0]   address_hold, address_hold_next;
  logic [7:0]    last_reply, last_reply_next;
  rsp_t          result_next;

  logic          accept;
  logic [CW:0]   count_inc;
  logic [8:0]    poll_inc;
  logic [7:0]    plim, wlim;
  logic          go_en;
  phase_t        go_phase;
  logic          quiet, fin, fail;
  logic [5:0]    cmd_code;
  logic [31:0]   cmd_arg;
  logic [7:0]    cmd_crc;
  logic [7:0]    cmd_tx;
  logic [7:0]    tx;
  logic          sel, taken;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign count_inc = {1'b0, byte_count} + 1'b1;
  assign poll_inc  = {1'b0, poll_count} + 1'b1;
  assign plim      = (poll_limit == 8'd0) ? 8'd1 : poll_limit;
  assign wlim      = (wake_bytes == 8'd0) ? 8'd1 : wake_bytes;

  // Next state: one step of the sequence per request.
  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    poll_count_next   = poll_count;
    address_hold_next = address_hold;
    last_reply_next   = last_reply;
    go_en             = 1'b0;
    go_phase          = phase;
    quiet             = 1'b0;
    fin               = 1'b0;
    fail              = 1'b0;
    if (req.payload.func == FUNC_INIT) begin
      go_en    = 1'b1;
      go_phase = PH_WAKE;
    end else if (req.payload.func == FUNC_WRITE) begin
      address_hold_next = req.payload.block_address;
      go_en             = 1'b1;
      go_phase          = PH_C24_SEND;
    end else if (req.payload.func == FUNC_NONE || phase == PH_IDLE) begin
      quiet = 1'b1;
    end else begin
      unique case (phase)
        PH_WAKE: begin
          if (count_inc >= (CW+1)'(wlim)) begin
            go_en    = 1'b1;
            go_phase = PH_C0_SEND;
          end else begin
            byte_count_next = count_inc[CW-1:0];
          end
        end
        PH_C0_SEND, PH_C8_SEND, PH_C55_SEND, PH_C41_SEND, PH_C24_SEND: begin
          if (count_inc >= (CW+1)'(CMD_BYTES)) begin
            go_en    = 1'b1;
            go_phase = phase_t'(phase + 5'd1);
          end else begin
            byte_count_next = count_inc[CW-1:0];
          end
        end
        PH_C0_POLL, PH_C8_POLL, PH_C55_POLL, PH_C41_POLL, PH_C24_POLL: begin
          if (req.payload.rx_byte != BYTE_IDLE || poll_inc >= {1'b0, plim}) begin
            last_reply_next = req.payload.rx_byte;
            go_en           = 1'b1;
            if (phase == PH_C24_POLL) begin
              if (req.payload.rx_byte != REPLY_READY) begin
                go_phase = PH_IDLE;
                quiet    = 1'b1;
                fin      = 1'b1;
                fail     = 1'b1;
              end else begin
                go_phase = PH_TOKEN;
              end
            end else begin
              go_phase = phase_t'(phase + 5'd1);
            end
          end else begin
            poll_count_next = poll_inc[7:0];
          end
        end
        PH_C0_TAIL: begin
          go_en    = 1'b1;
          go_phase = (last_reply == REPLY_IDLE) ? PH_C8_SEND : PH_C0_SEND;
        end
        PH_C8_R7: begin
          if (count_inc >= (CW+1)'(R7_BYTES)) begin
            go_en    = 1'b1;
            go_phase = PH_C8_TAIL;
          end else begin
            byte_count_next = count_inc[CW-1:0];
          end
        end
        PH_C8_TAIL: begin
          go_en    = 1'b1;
          go_phase = PH_C55_SEND;
        end
        PH_C55_TAIL: begin
          go_en    = 1'b1;
          go_phase = PH_C41_SEND;
        end
        PH_C41_TAIL: begin
          go_en = 1'b1;
          if (last_reply == REPLY_READY) begin
            go_phase = PH_IDLE;
            quiet    = 1'b1;
            fin      = 1'b1;
          end else begin
            go_phase = PH_C55_SEND;
          end
        end
        PH_TOKEN: begin
          go_en    = 1'b1;
          go_phase = PH_DATA;
        end
        PH_DATA: begin
          if (count_inc >= (CW+1)'(BLOCK_BYTES)) begin
            go_en    = 1'b1;
            go_phase = PH_CRC;
          end else begin
            byte_count_next = count_inc[CW-1:0];
          end
        end
        PH_CRC: begin
          if (count_inc >= (CW+1)'(CRC_BYTES)) begin
            go_en    = 1'b1;
            go_phase = PH_DRESP;
          end else begin
            byte_count_next = count_inc[CW-1:0];
          end
        end
        PH_DRESP: begin
          last_reply_next = req.payload.rx_byte;
          go_en           = 1'b1;
          go_phase        = PH_BUSY;
        end
        PH_BUSY: begin
          if (req.payload.rx_byte == BYTE_IDLE) begin
            go_en    = 1'b1;
            go_phase = PH_W_TAIL;
          end
        end
        default: begin
          // Write tail: the operation is over.
          go_en    = 1'b1;
          go_phase = PH_IDLE;
          quiet    = 1'b1;
          fin      = 1'b1;
        end
      endcase
    end
    if (go_en) begin
      phase_next      = go_phase;
      byte_count_next = '0;
      poll_count_next = '0;
    end
  end

  // Command frame fields for the phase about to be sent.
  always_comb begin
    cmd_code = CMD_WRITE;
    cmd_arg  = address_hold_next;
    cmd_crc  = BYTE_IDLE;
    unique case (phase_next)
      PH_C0_SEND: begin
        cmd_code = CMD_GO_IDLE;
        cmd_arg  = '0;
        cmd_crc  = CRC_GO_IDLE;
      end
      PH_C8_SEND: begin
        cmd_code = CMD_IF_COND;
        cmd_arg  = ARG_IF_COND;
        cmd_crc  = CRC_IF_COND;
      end
      PH_C55_SEND: begin
        cmd_code = CMD_APP;
        cmd_arg  = '0;
      end
      PH_C41_SEND: begin
        cmd_code = CMD_OP_COND;
        cmd_arg  = ARG_OP_COND;
      end
      default: begin
      end
    endcase
    case (byte_count_next[2:0])
      3'd0:    cmd_tx = CMD_START | {2'b00, cmd_code};
      3'd1:    cmd_tx = cmd_arg[31:24];
      3'd2:    cmd_tx = cmd_arg[23:16];
      3'd3:    cmd_tx = cmd_arg[15:8];
      3'd4:    cmd_tx = cmd_arg[7:0];
      default: cmd_tx = cmd_crc;
    endcase
  end

  // Byte to exchange next, chosen by the new phase.
  always_comb begin
    tx    = BYTE_IDLE;
    sel   = 1'b1;
    taken = 1'b0;
    case (phase_next)
      PH_WAKE, PH_C0_TAIL, PH_C8_TAIL, PH_C55_TAIL, PH_C41_TAIL, PH_W_TAIL: begin
        sel = 1'b0;
      end
      PH_C0_SEND, PH_C8_SEND, PH_C55_SEND, PH_C41_SEND, PH_C24_SEND: begin
        tx = cmd_tx;
      end
      PH_TOKEN: begin
        tx = TOKEN_START;
      end
      PH_DATA: begin
        tx    = req.payload.data_byte;
        taken = 1'b1;
      end
      default: begin
      end
    endcase
    result_next.send        = !quiet;
    result_next.tx_byte     = quiet ? 8'h00 : tx;
    result_next.select_card = !quiet && sel;
    result_next.data_taken  = !quiet && taken;
    result_next.finished    = fin;
    result_next.failed      = fail;
    result_next.response    = last_reply_next;
  end

  // State, configuration and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit   <= POLL_LIMIT_RESET;
      wake_bytes   <= WAKE_BYTES_RESET;
      phase        <= PH_IDLE;
      byte_count   <= '0;
      poll_count   <= '0;
      address_hold <= '0;
      last_reply   <= BYTE_IDLE;
      rsp.valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_POLL_LIMIT: poll_limit <= cfg_data;
          REG_WAKE_BYTES: wake_bytes <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        phase        <= phase_next;
        byte_count   <= byte_count_next;
        poll_count   <= poll_count_next;
        address_hold <= address_hold_next;
        last_reply   <= last_reply_next;
        rsp.valid    <= 1'b1;
        rsp.payload  <= result_next;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // A payload byte is only ever sent with the card selected.
  a_taken_selected: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.payload.data_taken |-> rsp.payload.send && rsp.payload.select_card)
    else $error("payload byte taken without a selected exchange");

  // An end report leaves the sequencer idle and issues no exchange.
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.payload.finished |-> phase == PH_IDLE && !rsp.payload.send)
    else $error("finished reported while an exchange is pending");

  // A failure is always an end report.
  a_fail_finish: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.payload.failed |-> rsp.payload.finished)
    else $error("failed without finished");

  // A start of init answers with a deselected idle byte in the next cycle.
  a_init_wake: assert property (@(posedge clk) disable iff (rst)
    accept && req.payload.func == FUNC_INIT |=>
      rsp.valid && !rsp.payload.select_card && rsp.payload.tx_byte == BYTE_IDLE)
    else $error("init did not start with a wake byte");

  // A start of write opens with the CMD24 command byte.
  a_write_cmd: assert property (@(posedge clk) disable iff (rst)
    accept && req.payload.func == FUNC_WRITE |=>
      rsp.valid && rsp.payload.select_card && phase == PH_C24_SEND &&
      rsp.payload.tx_byte == (CMD_START | {2'b00, CMD_WRITE}))
    else $error("write did not start with its command byte");

endmodule
